// ===== hdl/cdfs_pkg.sv =====
package cdfs_pkg;

  // table geometry
  localparam int BINS     = 256;
  localparam int BIN_W    = $clog2(BINS);
  localparam int WEIGHT_W = 16;
  localparam int FRAC_W   = 16;
  localparam int PFX_W    = 24;
  localparam int HIT_W    = 16;
  localparam int PROD_W   = PFX_W + FRAC_W;

  localparam logic [BIN_W:0]   BINS_CNT = (BIN_W + 1)'(BINS);
  localparam logic [PFX_W-1:0] PFX_MAX  = '1;
  localparam logic [HIT_W-1:0] HIT_MAX  = '1;

  // request types
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  // result status codes
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_EMPTY = 1'b1;

  // control from the search sequencer to the hit counter store
  typedef struct packed {
    logic             clear;
    logic [BIN_W-1:0] rd_addr;
    logic             incr;
    logic [BIN_W-1:0] incr_addr;
  } cdfs_cnt_ctrl_t;

endpackage

// ===== hdl/cdfs_intf.sv =====
// request channel
interface cdfs_req_if import cdfs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [BIN_W-1:0]    bin_index;
  logic [WEIGHT_W-1:0] weight;
  logic [FRAC_W-1:0]   random_fraction;

  modport source(output valid, req_type, bin_index, weight, random_fraction, input ready);
  modport sink(input valid, req_type, bin_index, weight, random_fraction, output ready);
endinterface

// result channel
interface cdfs_res_if import cdfs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BIN_W-1:0] hit_bin;
  logic [HIT_W-1:0] hit_count;
  logic             status;

  modport source(output valid, hit_bin, hit_count, status, input ready);
  modport sink(input valid, hit_bin, hit_count, status, output ready);
endinterface

// ===== hdl/cdfs_counter.sv =====
module cdfs_counter import cdfs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cdfs_cnt_ctrl_t   ctrl,
  output logic [HIT_W-1:0] cnt_new
);

  logic [HIT_W-1:0] cnt_mem [BINS];
  logic [BINS-1:0]  vld_r;
  logic [HIT_W-1:0] cnt_q_r;
  logic             vld_q_r;

  // per-entry valid bits, a cleared entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctrl.clear) begin
      vld_r <= '0;
    end else if (ctrl.incr) begin
      vld_r[ctrl.incr_addr] <= 1'b1;
    end
  end

  // count memory, registered read
  always_ff @(posedge clk) begin
    if (ctrl.incr) begin
      cnt_mem[ctrl.incr_addr] <= cnt_new;
    end
    cnt_q_r <= cnt_mem[ctrl.rd_addr];
    vld_q_r <= vld_r[ctrl.rd_addr];
  end

  // saturating increment of the entry read last cycle
  always_comb begin
    if (!vld_q_r) begin
      cnt_new = HIT_W'(1);
    end else if (cnt_q_r == HIT_MAX) begin
      cnt_new = HIT_MAX;
    end else begin
      cnt_new = cnt_q_r + HIT_W'(1);
    end
  end

endmodule

// ===== hdl/cdf_sampler_histogram.sv =====
// load: taken in idle, the table write and running sum update together
// draw: idle registers the target, search steps, finish writes the result register
// one item at a time; each search step costs one read of the prefix memory
// a waiting result does not block new input, only the next result write
// reset (synchronous, active low) clears the fill count, total and count valid bits;
// no clearing pass, the block takes input in the first cycle after reset
module cdf_sampler_histogram import cdfs_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  cdfs_req_if.sink  in_req,
  cdfs_res_if.source out_res
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_STEP = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [BIN_W:0]    bins_r, bins_nxt;
  logic [PFX_W-1:0]  total_r, total_nxt;
  logic [BIN_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [PROD_W-1:0] target_r, target_nxt;
  logic              empty_r, empty_nxt;

  logic              out_vld_r, out_vld_nxt;
  logic [BIN_W-1:0]  out_bin_r;
  logic [HIT_W-1:0]  out_cnt_r;
  logic              out_st_r;
  logic              out_load;
  logic              out_free;

  logic [PFX_W-1:0]  pfx_mem [BINS];
  logic [PFX_W-1:0]  pfx_q_r;
  logic [BIN_W-1:0]  pfx_rd_addr;
  logic              pfx_we;
  logic [BIN_W-1:0]  pfx_wr_addr;

  logic              in_xfer;
  logic              restart;
  logic [BIN_W:0]    base_bins;
  logic [PFX_W-1:0]  base_total;
  logic              load_ok;
  logic [PFX_W:0]    wsum;
  logic [PFX_W-1:0]  ld_sum;
  logic [PROD_W-1:0] prod;
  logic [BIN_W-1:0]  init_hi;
  logic              ge;
  logic [BIN_W-1:0]  s_lo, s_hi, s_mid;

  cdfs_cnt_ctrl_t    cnt_ctrl;
  logic [HIT_W-1:0]  cnt_new;

  cdfs_counter u_counter (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (cnt_ctrl),
    .cnt_new (cnt_new)
  );

  // handshake
  assign in_req.ready = (state_r == S_IDLE);
  assign in_xfer      = in_req.valid && in_req.ready;
  assign out_free     = !out_vld_r || out_res.ready;

  // load path: restart at index zero, saturating running sum
  assign restart    = (in_req.bin_index == '0);
  assign base_bins  = restart ? '0 : bins_r;
  assign base_total = restart ? '0 : total_r;
  assign load_ok    = ({1'b0, in_req.bin_index} == base_bins) && (base_bins < BINS_CNT);
  assign wsum       = {1'b0, base_total} + {{(PFX_W + 1 - WEIGHT_W){1'b0}}, in_req.weight};
  assign ld_sum     = wsum[PFX_W] ? PFX_MAX : wsum[PFX_W-1:0];

  // draw target, registered before the first compare
  assign prod    = {{PFX_W{1'b0}}, in_req.random_fraction} * {{FRAC_W{1'b0}}, total_r};
  assign init_hi = BIN_W'(bins_r - (BIN_W + 1)'(1));

  // one search step on the prefix read back this cycle
  assign ge = {pfx_q_r, {FRAC_W{1'b0}}} >= target_r;
  always_comb begin
    if (ge) begin
      s_lo = lo_r;
      s_hi = mid_r;
    end else begin
      s_lo = mid_r + BIN_W'(1);
      s_hi = hi_r;
    end
    s_mid = s_lo + ((s_hi - s_lo) >> 1);
  end

  // sequencer
  always_comb begin
    state_nxt          = state_r;
    bins_nxt           = bins_r;
    total_nxt          = total_r;
    lo_nxt             = lo_r;
    hi_nxt             = hi_r;
    mid_nxt            = mid_r;
    target_nxt         = target_r;
    empty_nxt          = empty_r;
    pfx_we             = 1'b0;
    pfx_wr_addr        = base_bins[BIN_W-1:0];
    pfx_rd_addr        = mid_r;
    out_load           = 1'b0;
    cnt_ctrl.clear     = 1'b0;
    cnt_ctrl.rd_addr   = lo_r;
    cnt_ctrl.incr      = 1'b0;
    cnt_ctrl.incr_addr = lo_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer && in_req.req_type == REQ_LOAD) begin
          cnt_ctrl.clear = restart;
          bins_nxt       = base_bins;
          total_nxt      = base_total;
          if (load_ok) begin
            pfx_we    = 1'b1;
            bins_nxt  = base_bins + (BIN_W + 1)'(1);
            total_nxt = ld_sum;
          end
        end else if (in_xfer) begin
          if (bins_r == '0 || total_r == '0) begin
            empty_nxt = 1'b1;
            state_nxt = S_FIN;
          end else begin
            empty_nxt        = 1'b0;
            target_nxt       = prod;
            lo_nxt           = '0;
            hi_nxt           = init_hi;
            mid_nxt          = init_hi >> 1;
            pfx_rd_addr      = init_hi >> 1;
            cnt_ctrl.rd_addr = '0;
            state_nxt        = (init_hi == '0) ? S_FIN : S_STEP;
          end
        end
      end
      S_STEP: begin
        lo_nxt           = s_lo;
        hi_nxt           = s_hi;
        mid_nxt          = s_mid;
        pfx_rd_addr      = s_mid;
        cnt_ctrl.rd_addr = s_lo;
        if (s_lo >= s_hi) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_load      = 1'b1;
          cnt_ctrl.incr = !empty_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_vld_nxt = out_load ? 1'b1 : (out_res.ready ? 1'b0 : out_vld_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      bins_r    <= '0;
      total_r   <= '0;
      out_vld_r <= 1'b0;
      empty_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      bins_r    <= bins_nxt;
      total_r   <= total_nxt;
      out_vld_r <= out_vld_nxt;
      empty_r   <= empty_nxt;
    end
  end

  // search datapath registers
  always_ff @(posedge clk) begin
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    target_r <= target_nxt;
  end

  // prefix sum memory, registered read
  always_ff @(posedge clk) begin
    if (pfx_we) begin
      pfx_mem[pfx_wr_addr] <= ld_sum;
    end
    pfx_q_r <= pfx_mem[pfx_rd_addr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bin_r <= empty_r ? '0 : lo_r;
      out_cnt_r <= empty_r ? '0 : cnt_new;
      out_st_r  <= empty_r ? ST_EMPTY : ST_OK;
    end
  end

  assign out_res.valid     = out_vld_r;
  assign out_res.hit_bin   = out_bin_r;
  assign out_res.hit_count = out_cnt_r;
  assign out_res.status    = out_st_r;

  // search window stays open while stepping
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STEP |-> lo_r < hi_r)
    else $error("search window empty while stepping");

  // chosen bin lies inside the loaded table
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && !empty_r) |-> ({1'b0, lo_r} < bins_r))
    else $error("selected bin beyond loaded table");

  // fill count never exceeds the table size
  assert property (@(posedge clk) disable iff (!rst_n)
    bins_r <= BINS_CNT)
    else $error("fill count overflow");

  // a counted draw always shows a nonzero ok result
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_ctrl.incr |=> out_vld_r && out_cnt_r != '0 && out_st_r == ST_OK)
    else $error("counted draw gave a zero or error result");

  // a restart load leaves exactly one bin loaded
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_req.req_type == REQ_LOAD && restart) |=> bins_r == (BIN_W + 1)'(1))
    else $error("restart load did not reset the table");

endmodule
